// ===== rtl/core/gsfe_pkg.sv =====
// Shared types, constants and fixed-point helpers for the GIMP shape function evaluator.
`default_nettype none

package gsfe_pkg;

   localparam int DATA_W    = 32;
   localparam int HALF_W    = 31;
   localparam int CELL_W    = 31;
   localparam int DIMS_W    = 2;
   localparam int WEIGHT_W  = 17;
   localparam int NUM_AXES  = 3;
   localparam int LANES     = 2 * NUM_AXES;
   localparam int NUM_W     = 80;
   localparam int DEN_W     = 64;
   localparam int Q_W       = 34;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 31;

   localparam logic [CSR_IDX_W-1:0] CSR_CELL_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_DIMS  = 1'b1;

   localparam logic [CELL_W-1:0]   CELL_SIZE_RESET = 31'd65536;
   localparam logic [DIMS_W-1:0]   DIMS_RESET      = 2'd2;
   localparam logic [DIMS_W-1:0]   DIMS_3D         = 2'd3;
   localparam logic [Q_W-1:0]      TERM_CAP        = 34'h2_0000_0000;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE      = 17'h1_0000;

   typedef logic signed [DATA_W-1:0] q_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] delta_x;
      logic signed [DATA_W-1:0] delta_y;
      logic signed [DATA_W-1:0] delta_z;
      logic [HALF_W-1:0]        half_x;
      logic [HALF_W-1:0]        half_y;
      logic [HALF_W-1:0]        half_z;
   } req_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0]      weight;
      logic signed [DATA_W-1:0] grad_x;
      logic signed [DATA_W-1:0] grad_y;
      logic signed [DATA_W-1:0] grad_z;
   } rsp_type;

   typedef enum logic [1:0] {
      VK_ZERO,
      VK_INNER,
      VK_TAIL,
      VK_FLANK
   } vkind_type;

   typedef enum logic [1:0] {
      SK_ZERO,
      SK_TAIL,
      SK_FLANK,
      SK_INNER
   } skind_type;

   typedef struct packed {
      vkind_type vkind;
      skind_type skind;
      logic      sneg;
   } axis_tag_type;

   function automatic q_type sat_pos(input logic [Q_W-1:0] q);
      if (q > Q_W'(32'h7fff_ffff)) begin
         return 32'sh7fff_ffff;
      end
      return q_type'(q[DATA_W-1:0]);
   endfunction

   function automatic q_type sat_neg(input logic [Q_W-1:0] q);
      if (q >= Q_W'(32'h8000_0000)) begin
         return 32'sh8000_0000;
      end
      return q_type'(~q[DATA_W-1:0] + 32'd1);
   endfunction

   function automatic q_type one_minus(input logic [Q_W-1:0] q);
      logic signed [Q_W+1:0] x;
      x = 36'sd65536 - $signed({2'b00, q});
      if (x < -36'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return q_type'(x[DATA_W-1:0]);
   endfunction

   function automatic q_type mulq(input q_type a, input q_type b);
      logic                neg;
      logic [DATA_W-1:0]   ma;
      logic [DATA_W-1:0]   mb;
      logic [2*DATA_W-1:0] prod;
      logic [2*DATA_W-1:0] pr;
      neg  = a[DATA_W-1] ^ b[DATA_W-1];
      ma   = a[DATA_W-1] ? (~a + 32'd1) : a;
      mb   = b[DATA_W-1] ? (~b + 32'd1) : b;
      prod = ma * mb;
      pr   = (prod + 64'd32768) >> 16;
      if (neg) begin
         return sat_neg(pr > 64'h3_ffff_ffff ? TERM_CAP : pr[Q_W-1:0]);
      end
      return sat_pos(pr > 64'h3_ffff_ffff ? TERM_CAP : pr[Q_W-1:0]);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gsfe_prep.sv =====
// Region decode and numerator/divisor formation for the three axes.
`default_nettype none

module gsfe_prep (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            adv,
   input  wire logic                            in_valid,
   input  wire gsfe_pkg::req_type               in_data,
   input  wire logic [gsfe_pkg::CELL_W-1:0]     cell_size,
   output logic                                 out_valid,
   output logic [gsfe_pkg::NUM_W-1:0]           out_num [gsfe_pkg::LANES],
   output logic [gsfe_pkg::DEN_W-1:0]           out_den [gsfe_pkg::LANES],
   output gsfe_pkg::axis_tag_type               out_tag [gsfe_pkg::NUM_AXES]
);

   localparam int NA = gsfe_pkg::NUM_AXES;
   localparam int NL = gsfe_pkg::LANES;

   logic signed [33:0]                 d_c [NA];
   logic signed [33:0]                 p_c [NA];
   logic signed [33:0]                 l_c;
   logic signed [33:0]                 ad_c [NA];
   logic signed [33:0]                 t_c [NA];
   logic                               inner_c [NA];
   logic                               lt_c [NA];
   logic                               rt_c [NA];
   logic                               lf_c [NA];
   logic                               rf_c [NA];

   logic                               v1_ff, v2_ff, v3_ff;
   logic [31:0]                        ad1_ff [NA], ad1_in [NA];
   logic [32:0]                        t1_ff [NA], t1_in [NA];
   logic [gsfe_pkg::HALF_W-1:0]        p1_ff [NA], p1_in [NA];
   logic [gsfe_pkg::CELL_W-1:0]        l1_ff;
   gsfe_pkg::axis_tag_type             tag1_ff [NA], tag1_in [NA];

   logic [63:0]                        sq2_ff [NA];
   logic [61:0]                        pp2_ff [NA];
   logic [63:0]                        tt2_ff [NA];
   logic [61:0]                        lp2_ff [NA];
   logic [31:0]                        ad2_ff [NA];
   logic [32:0]                        t2_ff [NA];
   logic [gsfe_pkg::CELL_W-1:0]        l2_ff;
   gsfe_pkg::axis_tag_type             tag2_ff [NA];

   logic [gsfe_pkg::NUM_W-1:0]         num3_ff [NL], num3_in [NL];
   logic [gsfe_pkg::DEN_W-1:0]         den3_ff [NL], den3_in [NL];
   gsfe_pkg::axis_tag_type             tag3_ff [NA];

   always_comb begin
      d_c[0] = 34'(in_data.delta_x);
      d_c[1] = 34'(in_data.delta_y);
      d_c[2] = 34'(in_data.delta_z);
      p_c[0] = $signed({3'b000, in_data.half_x});
      p_c[1] = $signed({3'b000, in_data.half_y});
      p_c[2] = $signed({3'b000, in_data.half_z});
      l_c    = $signed({3'b000, cell_size});
      for (int a = 0; a < NA; a++) begin
         inner_c[a] = (-p_c[a] < d_c[a]) && (d_c[a] <= p_c[a]);
         lt_c[a]    = (-l_c - p_c[a] < d_c[a]) && (d_c[a] <= -l_c + p_c[a]);
         rt_c[a]    = (l_c - p_c[a] < d_c[a]) && (d_c[a] <= l_c + p_c[a]);
         lf_c[a]    = (-l_c + p_c[a] < d_c[a]) && (d_c[a] <= -p_c[a]);
         rf_c[a]    = (p_c[a] < d_c[a]) && (d_c[a] <= l_c - p_c[a]);
         ad_c[a]    = d_c[a][33] ? -d_c[a] : d_c[a];
         t_c[a]     = lt_c[a] ? (l_c + p_c[a] + d_c[a]) : (l_c + p_c[a] - d_c[a]);
         ad1_in[a]  = ad_c[a][31:0];
         t1_in[a]   = t_c[a][32:0];
         p1_in[a]   = p_c[a][gsfe_pkg::HALF_W-1:0];
         if (inner_c[a]) begin
            tag1_in[a].vkind = gsfe_pkg::VK_INNER;
         end else if (lt_c[a] || rt_c[a]) begin
            tag1_in[a].vkind = gsfe_pkg::VK_TAIL;
         end else if (lf_c[a] || rf_c[a]) begin
            tag1_in[a].vkind = gsfe_pkg::VK_FLANK;
         end else begin
            tag1_in[a].vkind = gsfe_pkg::VK_ZERO;
         end
         if (lt_c[a]) begin
            tag1_in[a].skind = gsfe_pkg::SK_TAIL;
            tag1_in[a].sneg  = 1'b0;
         end else if (lf_c[a]) begin
            tag1_in[a].skind = gsfe_pkg::SK_FLANK;
            tag1_in[a].sneg  = 1'b0;
         end else if (inner_c[a]) begin
            tag1_in[a].skind = gsfe_pkg::SK_INNER;
            tag1_in[a].sneg  = (d_c[a] > 34'sd0);
         end else if (rf_c[a]) begin
            tag1_in[a].skind = gsfe_pkg::SK_FLANK;
            tag1_in[a].sneg  = 1'b1;
         end else if (rt_c[a]) begin
            tag1_in[a].skind = gsfe_pkg::SK_TAIL;
            tag1_in[a].sneg  = 1'b1;
         end else begin
            tag1_in[a].skind = gsfe_pkg::SK_ZERO;
            tag1_in[a].sneg  = 1'b0;
         end
      end
   end

   always_comb begin
      for (int a = 0; a < NA; a++) begin
         case (tag2_ff[a].vkind)
            gsfe_pkg::VK_INNER: begin
               num3_in[2*a] = gsfe_pkg::NUM_W'({sq2_ff[a] + {2'b00, pp2_ff[a]}, 16'h0000});
               den3_in[2*a] = gsfe_pkg::DEN_W'({lp2_ff[a], 1'b0});
            end
            gsfe_pkg::VK_TAIL: begin
               num3_in[2*a] = gsfe_pkg::NUM_W'({tt2_ff[a], 16'h0000});
               den3_in[2*a] = gsfe_pkg::DEN_W'({lp2_ff[a], 2'b00});
            end
            gsfe_pkg::VK_FLANK: begin
               num3_in[2*a] = gsfe_pkg::NUM_W'({ad2_ff[a], 16'h0000});
               den3_in[2*a] = gsfe_pkg::DEN_W'(l2_ff);
            end
            default: begin
               num3_in[2*a] = '0;
               den3_in[2*a] = gsfe_pkg::DEN_W'(1);
            end
         endcase
         case (tag2_ff[a].skind)
            gsfe_pkg::SK_TAIL: begin
               num3_in[2*a+1] = gsfe_pkg::NUM_W'({t2_ff[a], 31'h0});
               den3_in[2*a+1] = gsfe_pkg::DEN_W'(lp2_ff[a]);
            end
            gsfe_pkg::SK_FLANK: begin
               num3_in[2*a+1] = gsfe_pkg::NUM_W'(64'h1_0000_0000);
               den3_in[2*a+1] = gsfe_pkg::DEN_W'(l2_ff);
            end
            gsfe_pkg::SK_INNER: begin
               num3_in[2*a+1] = gsfe_pkg::NUM_W'({ad2_ff[a], 32'h0});
               den3_in[2*a+1] = gsfe_pkg::DEN_W'(lp2_ff[a]);
            end
            default: begin
               num3_in[2*a+1] = '0;
               den3_in[2*a+1] = gsfe_pkg::DEN_W'(1);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         l1_ff <= cell_size;
         l2_ff <= l1_ff;
         for (int a = 0; a < NA; a++) begin
            ad1_ff[a]  <= ad1_in[a];
            t1_ff[a]   <= t1_in[a];
            p1_ff[a]   <= p1_in[a];
            tag1_ff[a] <= tag1_in[a];
            sq2_ff[a]  <= ad1_ff[a] * ad1_ff[a];
            pp2_ff[a]  <= p1_ff[a] * p1_ff[a];
            tt2_ff[a]  <= 64'(t1_ff[a] * t1_ff[a]);
            lp2_ff[a]  <= l1_ff * p1_ff[a];
            ad2_ff[a]  <= ad1_ff[a];
            t2_ff[a]   <= t1_ff[a];
            tag2_ff[a] <= tag1_ff[a];
            tag3_ff[a] <= tag2_ff[a];
         end
         for (int ln = 0; ln < NL; ln++) begin
            num3_ff[ln] <= num3_in[ln];
            den3_ff[ln] <= den3_in[ln];
         end
      end
   end

   assign out_valid = v3_ff;
   assign out_num   = num3_ff;
   assign out_den   = den3_ff;
   assign out_tag   = tag3_ff;

endmodule

`default_nettype wire

// ===== rtl/core/gsfe_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with rounding and saturation.
`default_nettype none

module gsfe_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            adv,
   input  wire logic                            in_valid,
   input  wire logic [gsfe_pkg::NUM_W-1:0]      in_num [gsfe_pkg::LANES],
   input  wire logic [gsfe_pkg::DEN_W-1:0]      in_den [gsfe_pkg::LANES],
   input  wire gsfe_pkg::axis_tag_type          in_tag [gsfe_pkg::NUM_AXES],
   output logic                                 out_valid,
   output logic [gsfe_pkg::Q_W-1:0]             out_quo [gsfe_pkg::LANES],
   output gsfe_pkg::axis_tag_type               out_tag [gsfe_pkg::NUM_AXES]
);

   localparam int NL    = gsfe_pkg::LANES;
   localparam int NA    = gsfe_pkg::NUM_AXES;
   localparam int QW    = gsfe_pkg::Q_W;
   localparam int NW    = gsfe_pkg::NUM_W;
   localparam int DW    = gsfe_pkg::DEN_W;
   localparam int CMP_W = DW + QW;

   logic [NW-1:0]          rem_ff [QW+1][NL], rem_in [QW+1][NL];
   logic [DW-1:0]          den_ff [QW+1][NL], den_in [QW+1][NL];
   logic [QW-1:0]          quo_ff [QW+1][NL], quo_in [QW+1][NL];
   logic                   over_ff [QW+1][NL], over_in [QW+1][NL];
   logic                   vld_ff [QW+1];
   gsfe_pkg::axis_tag_type tag_ff [QW+1][NA];
   logic [CMP_W-1:0]       sh_c [1:QW][NL];
   logic                   ge_c [1:QW][NL];
   logic                   rnd_c [NL];
   logic [QW:0]            qr_c [NL];
   logic [QW-1:0]          res_ff [NL], res_in [NL];
   logic                   res_vld_ff;
   gsfe_pkg::axis_tag_type res_tag_ff [NA];

   always_comb begin
      for (int ln = 0; ln < NL; ln++) begin
         rem_in[0][ln]  = in_num[ln];
         den_in[0][ln]  = in_den[ln];
         quo_in[0][ln]  = '0;
         over_in[0][ln] = (in_den[ln] == '0) ||
                          (CMP_W'(in_num[ln]) >= (CMP_W'(in_den[ln]) << QW));
      end
      for (int s = 1; s <= QW; s++) begin
         for (int ln = 0; ln < NL; ln++) begin
            sh_c[s][ln]    = CMP_W'(den_ff[s-1][ln]) << (QW - s);
            ge_c[s][ln]    = CMP_W'(rem_ff[s-1][ln]) >= sh_c[s][ln];
            rem_in[s][ln]  = ge_c[s][ln] ? NW'(CMP_W'(rem_ff[s-1][ln]) - sh_c[s][ln])
                                         : rem_ff[s-1][ln];
            quo_in[s][ln]  = quo_ff[s-1][ln] | (QW'(ge_c[s][ln]) << (QW - s));
            den_in[s][ln]  = den_ff[s-1][ln];
            over_in[s][ln] = over_ff[s-1][ln];
         end
      end
      for (int ln = 0; ln < NL; ln++) begin
         rnd_c[ln]  = ({1'b0, rem_ff[QW][ln][DW-1:0]} << 1) >= {1'b0, den_ff[QW][ln]};
         qr_c[ln]   = {1'b0, quo_ff[QW][ln]} + (QW+1)'(rnd_c[ln]);
         res_in[ln] = (over_ff[QW][ln] || (qr_c[ln] > {1'b0, gsfe_pkg::TERM_CAP}))
                      ? gsfe_pkg::TERM_CAP : qr_c[ln][QW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= QW; s++) begin
            vld_ff[s] <= 1'b0;
         end
         res_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int s = 1; s <= QW; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
         res_vld_ff <= vld_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s <= QW; s++) begin
            for (int ln = 0; ln < NL; ln++) begin
               rem_ff[s][ln]  <= rem_in[s][ln];
               den_ff[s][ln]  <= den_in[s][ln];
               quo_ff[s][ln]  <= quo_in[s][ln];
               over_ff[s][ln] <= over_in[s][ln];
            end
         end
         for (int a = 0; a < NA; a++) begin
            tag_ff[0][a] <= in_tag[a];
            for (int s = 1; s <= QW; s++) begin
               tag_ff[s][a] <= tag_ff[s-1][a];
            end
            res_tag_ff[a] <= tag_ff[QW][a];
         end
         for (int ln = 0; ln < NL; ln++) begin
            res_ff[ln] <= res_in[ln];
         end
      end
   end

   assign out_valid = res_vld_ff;
   assign out_quo   = res_ff;
   assign out_tag   = res_tag_ff;

endmodule

`default_nettype wire

// ===== rtl/core/gsfe_combine.sv =====
// Per-axis term saturation and the weight and gradient products.
`default_nettype none

module gsfe_combine (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            adv,
   input  wire logic                            in_valid,
   input  wire logic [gsfe_pkg::Q_W-1:0]        in_quo [gsfe_pkg::LANES],
   input  wire gsfe_pkg::axis_tag_type          in_tag [gsfe_pkg::NUM_AXES],
   input  wire logic [gsfe_pkg::DIMS_W-1:0]     num_dims,
   output logic                                 rsp_valid,
   output gsfe_pkg::rsp_type                    rsp_data
);

   localparam int NA = gsfe_pkg::NUM_AXES;

   gsfe_pkg::q_type   val_ff [NA], val_in [NA];
   gsfe_pkg::q_type   slp_ff [NA], slp_in [NA];
   logic              c1_vld_ff, c2_vld_ff, rsp_valid_ff;
   gsfe_pkg::q_type   mw_ff, mgx_ff, mgy_ff, vz_ff, sz_ff;
   gsfe_pkg::q_type   w_c, gx_c, gy_c, gz_c;
   logic              three_c;
   gsfe_pkg::rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin
      for (int a = 0; a < NA; a++) begin
         case (in_tag[a].vkind)
            gsfe_pkg::VK_INNER: val_in[a] = gsfe_pkg::one_minus(in_quo[2*a]);
            gsfe_pkg::VK_FLANK: val_in[a] = gsfe_pkg::one_minus(in_quo[2*a]);
            gsfe_pkg::VK_TAIL:  val_in[a] = gsfe_pkg::sat_pos(in_quo[2*a]);
            default:            val_in[a] = '0;
         endcase
         if (in_tag[a].skind == gsfe_pkg::SK_ZERO) begin
            slp_in[a] = '0;
         end else if (in_tag[a].sneg) begin
            slp_in[a] = gsfe_pkg::sat_neg(in_quo[2*a+1]);
         end else begin
            slp_in[a] = gsfe_pkg::sat_pos(in_quo[2*a+1]);
         end
      end
   end

   always_comb begin
      three_c = (num_dims == gsfe_pkg::DIMS_3D);
      w_c     = three_c ? gsfe_pkg::mulq(mw_ff, vz_ff) : mw_ff;
      gx_c    = three_c ? gsfe_pkg::mulq(mgx_ff, vz_ff) : mgx_ff;
      gy_c    = three_c ? gsfe_pkg::mulq(mgy_ff, vz_ff) : mgy_ff;
      gz_c    = three_c ? gsfe_pkg::mulq(mw_ff, sz_ff) : '0;
      if (w_c[gsfe_pkg::DATA_W-1]) begin
         rsp_data_in.weight = '0;
      end else if (w_c > $signed({15'h0, gsfe_pkg::WEIGHT_ONE})) begin
         rsp_data_in.weight = gsfe_pkg::WEIGHT_ONE;
      end else begin
         rsp_data_in.weight = w_c[gsfe_pkg::WEIGHT_W-1:0];
      end
      rsp_data_in.grad_x = gx_c;
      rsp_data_in.grad_y = gy_c;
      rsp_data_in.grad_z = gz_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_vld_ff    <= 1'b0;
         c2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         c1_vld_ff    <= in_valid;
         c2_vld_ff    <= c1_vld_ff;
         rsp_valid_ff <= c2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < NA; a++) begin
            val_ff[a] <= val_in[a];
            slp_ff[a] <= slp_in[a];
         end
         mw_ff       <= gsfe_pkg::mulq(val_ff[0], val_ff[1]);
         mgx_ff      <= gsfe_pkg::mulq(slp_ff[0], val_ff[1]);
         mgy_ff      <= gsfe_pkg::mulq(val_ff[0], slp_ff[1]);
         vz_ff       <= val_ff[2];
         sz_ff       <= slp_ff[2];
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/gimp_shape_function_eval.sv =====
// Top level of the uniform GIMP shape function and gradient evaluator.
// Accepts one particle-node pair per cycle and returns its weight and gradient
// through three decode and multiply stages, a 36-stage divider forming each
// 34-bit quotient one bit per stage for all six per-axis terms in parallel,
// and three stages of saturation and Q16.16 products. The whole pipeline
// advances together and holds only while a result beat waits at the output
// without ready, so throughput is one beat per cycle while the consumer takes
// results. Write cell_size and num_dims only while no beat is in flight.
`default_nettype none

module gimp_shape_function_eval (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire gsfe_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output gsfe_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [gsfe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [gsfe_pkg::CSR_DAT_W-1:0]    csr_data
);

   logic [gsfe_pkg::CELL_W-1:0] cell_size_ff;
   logic [gsfe_pkg::DIMS_W-1:0] num_dims_ff;
   logic                        adv;

   logic                        prep_valid;
   logic [gsfe_pkg::NUM_W-1:0]  prep_num [gsfe_pkg::LANES];
   logic [gsfe_pkg::DEN_W-1:0]  prep_den [gsfe_pkg::LANES];
   gsfe_pkg::axis_tag_type      prep_tag [gsfe_pkg::NUM_AXES];
   logic                        div_valid;
   logic [gsfe_pkg::Q_W-1:0]    div_quo [gsfe_pkg::LANES];
   gsfe_pkg::axis_tag_type      div_tag [gsfe_pkg::NUM_AXES];

   assign csr_ready = 1'b1;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff <= gsfe_pkg::CELL_SIZE_RESET;
         num_dims_ff  <= gsfe_pkg::DIMS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            gsfe_pkg::CSR_CELL_SIZE: cell_size_ff <= csr_data[gsfe_pkg::CELL_W-1:0];
            gsfe_pkg::CSR_NUM_DIMS:  num_dims_ff  <= csr_data[gsfe_pkg::DIMS_W-1:0];
            default: ;
         endcase
      end
   end

   gsfe_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .cell_size (cell_size_ff),
      .out_valid (prep_valid),
      .out_num   (prep_num),
      .out_den   (prep_den),
      .out_tag   (prep_tag)
   );

   gsfe_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (prep_valid),
      .in_num    (prep_num),
      .in_den    (prep_den),
      .in_tag    (prep_tag),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_tag   (div_tag)
   );

   gsfe_combine u_combine (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (div_valid),
      .in_quo    (div_quo),
      .in_tag    (div_tag),
      .num_dims  (num_dims_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.weight <= gsfe_pkg::WEIGHT_ONE)
      else $error("weight beat above one");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output beat is held");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output beat present after reset");
`endif

endmodule

`default_nettype wire

// ===== test/tb_gimp_shape_function_eval.sv =====
// Self-checking testbench for the GIMP shape function evaluator with random flow control.
`default_nettype none

module tb_gimp_shape_function_eval;
   import gsfe_pkg::*;

   localparam longint Q_UNIT   = 65536;
   localparam longint MAG_CAP  = 64'h2_0000_0000;
   localparam longint INT_HIGH = 64'sh7fff_ffff;
   localparam longint INT_LOW  = -64'sh8000_0000;

   class shape_scoreboard;
      rsp_type     awaited[$];
      logic [30:0] cell_len;
      logic [1:0]  dims;
      int          errors;

      function new();
         cell_len = CELL_SIZE_RESET;
         dims     = DIMS_RESET;
         errors   = 0;
      endfunction

      function automatic bit [63:0] div_round(bit [63:0] a, bit [63:0] b, bit [63:0] c);
         bit [127:0] prod;
         bit [127:0] quo;
         bit [127:0] rem;
         bit [127:0] wide_c;
         if (c == 0) begin
            return '1;
         end
         wide_c = {64'd0, c};
         prod   = {64'd0, a} * {64'd0, b};
         quo    = prod / wide_c;
         rem    = prod % wide_c;
         if (quo[127:64] != 0) begin
            return '1;
         end
         if (rem >= wide_c - rem && quo[63:0] != '1) begin
            quo = quo + 1;
         end
         return quo[63:0];
      endfunction

      function automatic longint clamp(longint v);
         if (v > INT_HIGH) begin
            return INT_HIGH;
         end
         if (v < INT_LOW) begin
            return INT_LOW;
         end
         return v;
      endfunction

      function automatic longint term(bit [63:0] mag, bit neg);
         longint m;
         m = (mag > MAG_CAP) ? MAG_CAP : longint'(mag);
         return clamp(neg ? -m : m);
      endfunction

      function automatic longint one_less(bit [63:0] mag);
         longint m;
         m = (mag > MAG_CAP) ? MAG_CAP : longint'(mag);
         return clamp(Q_UNIT - m);
      endfunction

      function automatic longint qmul(longint a, longint b);
         bit [63:0] ma;
         bit [63:0] mb;
         bit [63:0] p;
         ma = (a < 0) ? -a : a;
         mb = (b < 0) ? -b : b;
         p  = (ma * mb + 64'd32768) >> 16;
         return term(p, (a < 0) != (b < 0));
      endfunction

      function automatic void axis(logic signed [31:0] dr, logic [30:0] hr,
                                   output longint val, output longint slope);
         longint    d;
         longint    p;
         longint    l;
         bit [63:0] ad;
         bit [63:0] lp;
         bit [63:0] t;
         bit [63:0] sq;
         d  = dr;
         p  = hr;
         l  = cell_len;
         ad = (d < 0) ? -d : d;
         lp = l * p;
         if (-p < d && d <= p) begin
            sq  = ad * ad + p * p;
            val = one_less(div_round(sq, Q_UNIT, lp << 1));
         end else if (-l - p < d && d <= -l + p) begin
            t   = l + p + d;
            sq  = t * t;
            val = term(div_round(sq, Q_UNIT, lp << 2), 1'b0);
         end else if (l - p < d && d <= l + p) begin
            t   = l + p - d;
            sq  = t * t;
            val = term(div_round(sq, Q_UNIT, lp << 2), 1'b0);
         end else if ((-l + p < d && d <= -p) || (p < d && d <= l - p)) begin
            val = one_less(div_round(ad, Q_UNIT, l));
         end else begin
            val = 0;
         end
         if (-l - p < d && d <= -l + p) begin
            slope = term(div_round(l + p + d, 64'd1 << 31, lp), 1'b0);
         end else if (-l + p < d && d <= -p) begin
            slope = term(div_round(1, 64'd1 << 32, l), 1'b0);
         end else if (-p < d && d <= p) begin
            slope = term(div_round(ad, 64'd1 << 32, lp), d > 0);
         end else if (p < d && d <= l - p) begin
            slope = term(div_round(1, 64'd1 << 32, l), 1'b1);
         end else if (l - p < d && d <= l + p) begin
            slope = term(div_round(l + p - d, 64'd1 << 31, lp), 1'b1);
         end else begin
            slope = 0;
         end
      endfunction

      function automatic void note(req_type r);
         longint  vx, vy, vz, sx, sy, sz, w, gx, gy, gz;
         rsp_type e;
         axis(r.delta_x, r.half_x, vx, sx);
         axis(r.delta_y, r.half_y, vy, sy);
         if (dims == DIMS_3D) begin
            axis(r.delta_z, r.half_z, vz, sz);
            w  = qmul(qmul(vx, vy), vz);
            gx = qmul(qmul(sx, vy), vz);
            gy = qmul(qmul(vx, sy), vz);
            gz = qmul(qmul(vx, vy), sz);
         end else begin
            w  = qmul(vx, vy);
            gx = qmul(sx, vy);
            gy = qmul(vx, sy);
            gz = 0;
         end
         if (w < 0) begin
            w = 0;
         end
         if (w > Q_UNIT) begin
            w = Q_UNIT;
         end
         e.weight = w[16:0];
         e.grad_x = gx[31:0];
         e.grad_y = gy[31:0];
         e.grad_z = gz[31:0];
         awaited.push_back(e);
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch %s: got %0h expected %0h", what, got, want);
         errors++;
      endtask

      task check(rsp_type got);
         rsp_type e;
         if (awaited.size() == 0) begin
            report("unexpected beat", got.weight, 0);
            return;
         end
         e = awaited.pop_front();
         if (got.weight !== e.weight) report("weight", got.weight, e.weight);
         if (got.grad_x !== e.grad_x) report("grad_x", got.grad_x, e.grad_x);
         if (got.grad_y !== e.grad_y) report("grad_y", got.grad_y, e.grad_y);
         if (got.grad_z !== e.grad_z) report("grad_z", got.grad_z, e.grad_z);
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_CELL_SIZE;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   shape_scoreboard sb = new();
   bit              calm = 1'b0;
   bit              choke = 1'b0;

   gimp_shape_function_eval uut (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check(rsp_data);
      end
   end

   initial begin
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (choke) begin
            choke = 1'b0;
            hold  = 400;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = calm || ($urandom_range(99) >= 26);
         end
      end
   end

   initial begin
      #(20 * 400000);
      $display("[gimp_shape_function_eval] ERROR");
      $finish;
   end

   task drain();
      while (sb.awaited.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   task write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_CELL_SIZE) sb.cell_len = val;
      else sb.dims = val[1:0];
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task setup(logic [30:0] cl, logic [1:0] nd);
      drain();
      write_reg(CSR_CELL_SIZE, cl);
      write_reg(CSR_NUM_DIMS, {29'd0, nd});
   endtask

   task send(req_type r);
      while (!calm && $urandom_range(99) < 26) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      do @(posedge clock); while (!req_ready);
      sb.note(r);
      @(negedge clock);
   endtask

   function automatic void pick_axis(longint cl, output logic [31:0] d, output logic [30:0] h);
      longint          hv;
      longint          lim;
      longint          dv;
      longint unsigned u;
      if ($urandom_range(9) == 0) begin
         d = $urandom;
         h = 31'($urandom);
         return;
      end
      if (cl < 1) cl = 1;
      case ($urandom_range(3))
         0: hv = 1 + longint'($urandom) % cl;
         1, 2: hv = 1 + longint'($urandom) % (cl / 2 + 1);
         default: hv = 1 + longint'($urandom) % (cl / 16 + 1);
      endcase
      if (hv > INT_HIGH) hv = INT_HIGH;
      lim = cl + 2 * hv;
      case ($urandom_range(7))
         0: dv = hv;
         1: dv = -hv;
         2: dv = cl - hv;
         3: dv = cl + hv;
         4: dv = -cl + hv;
         default: begin
            u  = {$urandom, $urandom};
            dv = longint'(u % longint'(2 * lim + 1)) - lim;
         end
      endcase
      if ($urandom_range(15) == 0) dv = dv + ($urandom_range(1) ? 1 : -1);
      if (dv > INT_HIGH) dv = INT_HIGH;
      if (dv < INT_LOW) dv = INT_LOW;
      d = dv[31:0];
      h = hv[30:0];
   endfunction

   task send_shaped(longint cl);
      req_type r;
      pick_axis(cl, r.delta_x, r.half_x);
      pick_axis(cl, r.delta_y, r.half_y);
      pick_axis(cl, r.delta_z, r.half_z);
      send(r);
   endtask

   task send_axes(logic [31:0] d, logic [30:0] h);
      req_type r;
      r.delta_x = d;
      r.half_x  = h;
      r.delta_y = -d;
      r.half_y  = h;
      r.delta_z = d >>> 1;
      r.half_z  = h;
      send(r);
   endtask

   initial begin
      logic [30:0] cells[9];
      logic [1:0]  modes[9];
      logic [30:0] cl;
      cells = '{31'd65536, 31'd65536, 31'd1, 31'h7fff_ffff, 31'd0,
                31'd200000, 31'd32768, 31'h7fff_ffff, 31'd0};
      modes = '{2'd3, 2'd2, 2'd3, 2'd2, 2'd3, 2'd0, 2'd1, 2'd3, 2'd3};
      repeat (12) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      setup(31'd65536, DIMS_3D);
      send_axes(32'h0, 31'd16384);
      send_axes(32'd16384, 31'd16384);
      send_axes(-32'sd16384, 31'd16384);
      send_axes(32'd49152, 31'd16384);
      send_axes(32'd81920, 31'd16384);
      send_axes(-32'sd81920, 31'd16384);
      send_axes(32'd98304, 31'd16384);
      send_axes(32'd30000, 31'd16384);
      send_axes(32'd60000, 31'd16384);
      send_axes(32'h8000_0000, 31'd1);
      send_axes(32'h7fff_ffff, 31'd1);
      send_axes(32'h8000_0000, 31'h7fff_ffff);
      send_axes(32'h7fff_ffff, 31'h7fff_ffff);
      send_axes(32'h0, 31'h7fff_ffff);
      send_axes(32'd20000, 31'd0);
      send_axes(32'h0, 31'd0);
      send_axes(32'd40000, 31'd50000);
      send_axes(32'd100000, 31'd50000);
      send_axes(32'hffff_ffff, 31'd1);
      send_axes(32'd1, 31'd65536);
      req_valid = 1'b0;

      for (int ph = 0; ph < 9; ph++) begin
         cl = (ph == 8) ? 31'($urandom) : cells[ph];
         setup(cl, modes[ph]);
         calm = (ph == 3);
         if (ph == 1) choke = 1'b1;
         repeat (76) send_shaped(cl == 0 ? 65536 : longint'(cl));
         req_valid = 1'b0;
         calm = 1'b0;
      end

      drain();
      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("[gimp_shape_function_eval] OK");
      end else begin
         $display("[gimp_shape_function_eval] ERROR");
      end
      $finish;
   end
endmodule

`default_nettype wire
